[sv/csp_pkg.sv]
`default_nettype none
package csp_pkg;

   // Request kinds as carried on req_tuser
   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_VALUE = 2'd1,
      OP_DERIV = 2'd2,
      OP_NONE  = 2'd3
   } csp_op_type;

   localparam int unsigned REQ_DATA_W = 200;
   localparam int unsigned RSP_DATA_W = 40;
   localparam int unsigned CSR_ADDR_W = 3;

   // Register indexes
   localparam logic [0:0] CSR_POINT_COUNT = 1'b0;
   localparam logic [8:0] POINT_COUNT_RST = 9'd2;

   // One queued transaction, already classified
   typedef struct packed {
      csp_op_type         op;
      logic [7:0]         entry_index;
      logic signed [31:0] knot_x;
      logic signed [31:0] coef_a;
      logic signed [31:0] coef_b;
      logic signed [31:0] coef_c;
      logic signed [31:0] coef_d;
      logic signed [31:0] query_x;
   } csp_entry_type;

endpackage
`default_nettype wire

[sv/csp_front.sv]
`default_nettype none
module csp_front
   import csp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [1:0]            req_tuser,
   output logic                       q_valid,
   output csp_entry_type              q_entry,
   input  wire logic                  q_pop
);

   csp_entry_type slot_ff [2];
   csp_entry_type new_entry;
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          push;
   logic          pop;

   // Classify the request kind
   always_comb begin
      unique case (req_tuser)
         2'd0:    new_entry.op = OP_LOAD;
         2'd1:    new_entry.op = OP_VALUE;
         2'd2:    new_entry.op = OP_DERIV;
         default: new_entry.op = OP_NONE;
      endcase
      new_entry.entry_index = req_tdata[7:0];
      new_entry.knot_x      = req_tdata[39:8];
      new_entry.coef_a      = req_tdata[71:40];
      new_entry.coef_b      = req_tdata[103:72];
      new_entry.coef_c      = req_tdata[135:104];
      new_entry.coef_d      = req_tdata[167:136];
      new_entry.query_x     = req_tdata[199:168];
   end

   // Two-entry queue towards the back end
   assign req_tready = (count_ff != 2'd2);
   assign q_valid    = (count_ff != 2'd0);
   assign q_entry    = slot_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule
`default_nettype wire

[sv/csp_back.sv]
`default_nettype none
module csp_back
   import csp_pkg::*;
#(
   parameter int unsigned MAX_POINTS = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [8:0]            point_count,
   input  wire logic                  q_valid,
   input  wire csp_entry_type         q_entry,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic [0:0]                 rsp_tuser
);

   localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int unsigned NW = $clog2(MAX_POINTS + 1);
   localparam int unsigned LW = NW + 1;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_FIRST = 8'b0000_0010,
      ST_LAST  = 8'b0000_0100,
      ST_SRCH  = 8'b0000_1000,
      ST_SEG   = 8'b0001_0000,
      ST_MUL   = 8'b0010_0000,
      ST_ADD   = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } csp_state_type;

   // Saturate a sign-extended value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   // Table memories
   logic signed [31:0] knot_mem  [MAX_POINTS];
   logic signed [31:0] const_mem [MAX_POINTS];
   logic signed [31:0] lin_mem   [MAX_POINTS];
   logic signed [31:0] quad_mem  [MAX_POINTS];
   logic signed [31:0] cubic_mem [MAX_POINTS];
   logic signed [31:0] rd_knot_ff, rd_a_ff, rd_b_ff, rd_c_ff, rd_d_ff;
   logic               mem_we;
   logic [IW-1:0]      waddr;
   logic [IW-1:0]      raddr;

   csp_state_type      state_ff, state_in;
   csp_op_type         op_ff, op_in;
   logic signed [31:0] qx_ff, qx_in;
   logic signed [31:0] k0_ff, k0_in;
   logic signed [31:0] klast_ff, klast_in;
   logic               asc_ff, asc_in;
   logic signed [LW-1:0] lo_ff, lo_in;
   logic signed [LW-1:0] hi_ff, hi_in;
   logic [IW-1:0]      mid_ff, mid_in;
   logic signed [31:0] dx_ff, dx_in;
   logic signed [31:0] acc_ff, acc_in;
   logic signed [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [1:0]         step_ff, step_in;
   logic signed [31:0] res_val_ff, res_val_in;
   logic [7:0]         res_seg_ff, res_seg_in;
   logic               res_oor_ff, res_oor_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_val_ff, rsp_val_in;
   logic [7:0]         rsp_seg_ff, rsp_seg_in;
   logic               rsp_oor_ff, rsp_oor_in;

   logic               out_free;
   logic [NW-1:0]      n_pts;
   logic signed [LW-1:0] n_minus1;
   logic signed [LW-1:0] mid_ext, nlo, nhi;
   logic [LW:0]        nsum, ndiff;
   logic               go_lo;
   logic               oor;
   logic signed [63:0] q_prod;
   logic signed [31:0] coef_sel, add_res;
   logic               last_step;

   // Point count clamped to at least 2 and at most the table size
   always_comb begin
      if (point_count < 9'd2) n_pts = NW'(2);
      else if (32'(point_count) > MAX_POINTS) n_pts = NW'(MAX_POINTS);
      else n_pts = NW'(point_count);
      n_minus1 = $signed(LW'(n_pts)) - LW'(1);
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_seg_ff, rsp_val_ff};
   assign rsp_tuser  = rsp_oor_ff;

   // Bisection step on the knot just read
   always_comb begin
      mid_ext = $signed(LW'(mid_ff));
      if (state_ff == ST_LAST) begin
         nlo = -LW'(1);
         nhi = $signed(LW'(n_pts));
         go_lo = 1'b0;
      end else begin
         go_lo = (($signed(qx_ff) >= $signed(rd_knot_ff)) == asc_ff);
         nlo = go_lo ? mid_ext : lo_ff;
         nhi = go_lo ? hi_ff : mid_ext;
      end
      nsum  = (LW+1)'(unsigned'(nlo)) + (LW+1)'(unsigned'(nhi));
      nsum[LW] = 1'b0;
      ndiff = (LW+1)'(unsigned'(nhi - nlo));
      oor   = lo_ff[LW-1] || ((lo_ff == n_minus1) && (qx_ff != klast_ff));
   end

   // Horner step
   always_comb begin
      q_prod = prod_ff >>> 16;
      unique case (step_ff)
         2'd0:    coef_sel = c_ff;
         2'd1:    coef_sel = b_ff;
         default: coef_sel = a_ff;
      endcase
      add_res   = sat32(64'(sat32(q_prod)) + 64'(coef_sel));
      last_step = (step_ff == 2'd2) || ((op_ff == OP_DERIV) && (step_ff == 2'd1));
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      qx_in      = qx_ff;
      k0_in      = k0_ff;
      klast_in   = klast_ff;
      asc_in     = asc_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      dx_in      = dx_ff;
      acc_in     = acc_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      c_in       = c_ff;
      prod_in    = prod_ff;
      step_in    = step_ff;
      res_val_in = res_val_ff;
      res_seg_in = res_seg_ff;
      res_oor_in = res_oor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_val_in = rsp_val_ff;
      rsp_seg_in = rsp_seg_ff;
      rsp_oor_in = rsp_oor_ff;
      q_pop      = 1'b0;
      mem_we     = 1'b0;
      waddr      = IW'(q_entry.entry_index);
      raddr      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               op_in = q_entry.op;
               qx_in = q_entry.query_x;
               if ((q_entry.op == OP_VALUE) || (q_entry.op == OP_DERIV)) begin
                  state_in = ST_FIRST;
               end else begin
                  mem_we = (q_entry.op == OP_LOAD) &&
                           (32'(q_entry.entry_index) < MAX_POINTS);
                  rsp_valid_in = 1'b1;
                  rsp_val_in   = '0;
                  rsp_seg_in   = '0;
                  rsp_oor_in   = 1'b0;
               end
            end
         end
         ST_FIRST: begin
            k0_in    = rd_knot_ff;
            raddr    = IW'(n_minus1);
            state_in = ST_LAST;
         end
         ST_LAST: begin
            klast_in = rd_knot_ff;
            asc_in   = $signed(rd_knot_ff) > $signed(k0_ff);
            lo_in    = nlo;
            hi_in    = nhi;
            mid_in   = IW'(nsum >> 1);
            raddr    = IW'(nsum >> 1);
            state_in = ST_SRCH;
         end
         ST_SRCH: begin
            lo_in = nlo;
            hi_in = nhi;
            if (ndiff > (LW+1)'(1)) begin
               mid_in = IW'(nsum >> 1);
               raddr  = IW'(nsum >> 1);
            end else begin
               raddr    = IW'(nlo);
               state_in = ST_SEG;
            end
         end
         ST_SEG: begin
            if (oor) begin
               res_val_in = '0;
               res_seg_in = '0;
               res_oor_in = 1'b1;
               state_in   = ST_OUT;
            end else begin
               dx_in   = sat32(64'(qx_ff) - 64'(rd_knot_ff));
               a_in    = rd_a_ff;
               b_in    = rd_b_ff;
               // derivative uses 2c and 3d
               c_in    = (op_ff == OP_DERIV) ? sat32(64'(rd_c_ff) * 64'sd2) : rd_c_ff;
               acc_in  = (op_ff == OP_DERIV) ? sat32(64'(rd_d_ff) * 64'sd3) : rd_d_ff;
               step_in = 2'd0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = 64'(dx_ff) * 64'(acc_ff);
            state_in = ST_ADD;
         end
         ST_ADD: begin
            acc_in = add_res;
            if (last_step) begin
               res_val_in = add_res;
               res_seg_in = 8'(lo_ff[IW-1:0]);
               res_oor_in = 1'b0;
               state_in   = ST_OUT;
            end else begin
               step_in  = step_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = res_val_ff;
               rsp_seg_in   = res_seg_ff;
               rsp_oor_in   = res_oor_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      qx_ff      <= qx_in;
      k0_ff      <= k0_in;
      klast_ff   <= klast_in;
      asc_ff     <= asc_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      dx_ff      <= dx_in;
      acc_ff     <= acc_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      c_ff       <= c_in;
      prod_ff    <= prod_in;
      step_ff    <= step_in;
      res_val_ff <= res_val_in;
      res_seg_ff <= res_seg_in;
      res_oor_ff <= res_oor_in;
      rsp_val_ff <= rsp_val_in;
      rsp_seg_ff <= rsp_seg_in;
      rsp_oor_ff <= rsp_oor_in;
   end

   // Table memories, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         knot_mem[waddr]  <= q_entry.knot_x;
         const_mem[waddr] <= q_entry.coef_a;
         lin_mem[waddr]   <= q_entry.coef_b;
         quad_mem[waddr]  <= q_entry.coef_c;
         cubic_mem[waddr] <= q_entry.coef_d;
      end
      rd_knot_ff <= knot_mem[raddr];
      rd_a_ff    <= const_mem[raddr];
      rd_b_ff    <= lin_mem[raddr];
      rd_c_ff    <= quad_mem[raddr];
      rd_d_ff    <= cubic_mem[raddr];
   end

endmodule
`default_nettype wire

[sv/cubic_spline_evaluator_top.sv]
// Channel  | Ports          | Contents
// request  | req_t*         | tuser: req_type; tdata: entry, knot, a, b, c, d, query_x
// response | rsp_t*         | tuser: out_of_range; tdata: result_value, segment_index
// config   | csr_p*         | point_count at byte address 0
//
// A load or an unknown kind is answered straight from the idle state of the back end. A query
// reads the first and last knots, runs a bisection search over the active knots, fetches the
// segment and runs 2 (derivative) or 3 (value) multiply-add pairs: the single knot memory
// read port sets the search, the shared multiplier the Horner steps.
// A two-entry queue takes requests while the back end is busy or stalled.
// Reset is synchronous; tables are undefined until loaded.
`default_nettype none
module cubic_spline_evaluator_top
   import csp_pkg::*;
#(
   parameter int unsigned MAX_POINTS = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // entry_index, knot_x, coef_a, coef_b, coef_c, coef_d, query_x
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  wire logic [1:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // result_value, segment_index
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // out_of_range
   output logic [0:0]                 rsp_tuser,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   logic [8:0]    pc_ff, pc_in;
   logic          q_valid;
   logic          q_pop;
   csp_entry_type q_entry;

   // Register port
   assign csr_pready = 1'b1;
   always_comb begin
      pc_in = pc_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          (csr_paddr[2] == CSR_POINT_COUNT)) begin
         pc_in = csr_pwdata[8:0];
      end
      csr_prdata = (csr_paddr[2] == CSR_POINT_COUNT) ? {23'd0, pc_ff} : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= POINT_COUNT_RST;
      end else begin
         pc_ff <= pc_in;
      end
   end

   csp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop)
   );

   csp_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .point_count (pc_ff),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
`default_nettype wire

[sv/csp_checker.sv]
`default_nettype none
module csp_checker
   import csp_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [REQ_DATA_W-1:0] req_tdata,
   input wire logic [1:0]            req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [0:0]            rsp_tuser,
   input wire logic                  csr_psel,
   input wire logic                  csr_penable,
   input wire logic                  csr_pwrite,
   input wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [31:0]           csr_pwdata,
   input wire logic [31:0]           csr_prdata,
   input wire logic                  csr_pready
);

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // Out of range carries zero value and segment
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("out of range response with nonzero payload");

   // Nothing pending after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pending transaction after reset");

   // Register port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_psel |-> csr_pready)
      else $error("register port stalled");

endmodule

bind cubic_spline_evaluator_top csp_checker u_csp_checker (.*);
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
   import csp_pkg::*;

   localparam int unsigned TABLE_DEPTH = 256;
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned DRAIN_WAIT  = 40;

   // Expected result of one transaction and the predictor that builds it
   class spline_scoreboard;
      typedef struct {
         logic signed [31:0] value;
         logic [7:0]         seg;
         logic               oor;
      } spline_result_type;

      logic signed [31:0] knot [TABLE_DEPTH];
      logic signed [31:0] ca [TABLE_DEPTH];
      logic signed [31:0] cb [TABLE_DEPTH];
      logic signed [31:0] cc [TABLE_DEPTH];
      logic signed [31:0] cd [TABLE_DEPTH];
      logic [8:0]         pcount;
      spline_result_type  result_q[$];
      int unsigned        mismatches;

      function new();
         pcount = POINT_COUNT_RST;
         mismatches = 0;
      endfunction

      function logic signed [31:0] sat32(input longint v);
         if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return v[31:0];
      endfunction

      // truncating Q16.16 product: floor via arithmetic shift
      function logic signed [31:0] qmul(input logic signed [31:0] p,
                                        input logic signed [31:0] q);
         longint prod;
         prod = longint'(p) * longint'(q);
         return sat32(prod >>> 16);
      endfunction

      function logic signed [31:0] qadd(input logic signed [31:0] p,
                                        input logic signed [31:0] q);
         return sat32(longint'(p) + longint'(q));
      endfunction

      function int unsigned active_knots();
         if (pcount < 2) return 2;
         if (pcount > TABLE_DEPTH) return TABLE_DEPTH;
         return pcount;
      endfunction

      function void note_input(input csp_entry_type t);
         spline_result_type r;
         int n, lo, hi, mid;
         bit ascending;
         logic signed [31:0] qx, dx, acc;
         r.value = '0;
         r.seg = '0;
         r.oor = 1'b0;
         qx = t.query_x;
         case (t.op)
            OP_LOAD: begin
               knot[t.entry_index] = t.knot_x;
               ca[t.entry_index] = t.coef_a;
               cb[t.entry_index] = t.coef_b;
               cc[t.entry_index] = t.coef_c;
               cd[t.entry_index] = t.coef_d;
            end
            OP_VALUE, OP_DERIV: begin
               n = active_knots();
               ascending = knot[n-1] > knot[0];
               lo = -1;
               hi = n;
               while (hi - lo > 1) begin
                  mid = (hi + lo) / 2;
                  if ((qx >= knot[mid]) == ascending) lo = mid;
                  else hi = mid;
               end
               if (lo < 0 || (lo == n - 1 && qx != knot[n-1])) begin
                  r.oor = 1'b1;
               end else begin
                  dx = sat32(longint'(qx) - longint'(knot[lo]));
                  if (t.op == OP_VALUE) begin
                     acc = cd[lo];
                     acc = qadd(cc[lo], qmul(dx, acc));
                     acc = qadd(cb[lo], qmul(dx, acc));
                     r.value = qadd(ca[lo], qmul(dx, acc));
                  end else begin
                     acc = sat32(longint'(cd[lo]) * 3);
                     acc = qadd(sat32(longint'(cc[lo]) * 2), qmul(dx, acc));
                     r.value = qadd(cb[lo], qmul(dx, acc));
                  end
                  r.seg = lo[7:0];
               end
            end
            default: ;
         endcase
         result_q.push_back(r);
      endfunction

      function void check_result(input logic signed [31:0] value,
                                 input logic [7:0] seg, input logic oor);
         spline_result_type e;
         if (result_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: value %h seg %0d oor %0d", value, seg, oor);
            return;
         end
         e = result_q.pop_front();
         if (e.value !== value || e.seg !== seg || e.oor !== oor) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch: exp value %h seg %0d oor %0d, got %h %0d %0d",
                        e.value, e.seg, e.oor, value, seg, oor);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   spline_scoreboard sb;
   int unsigned      cycles;
   bit               quiet;

   cubic_spline_evaluator_top u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[31:0], rsp_tdata[39:32], rsp_tuser[0]);
   end

   // receiver back-pressure: short stalls mostly, a few long ones
   initial begin : rsp_stall
      int hold;
      hold = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0)
               hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                  : $urandom_range(1, 3);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_item(input csp_entry_type t);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = t.op;
      req_tdata = {t.query_x, t.coef_d, t.coef_c, t.coef_b, t.coef_a, t.knot_x,
                   t.entry_index};
      do @(posedge clock); while (!req_tready);
      sb.note_input(t);
   endtask

   // sender idles until every transaction has returned, then the pipe settles
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.result_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(input logic [31:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {CSR_POINT_COUNT, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.pcount = value[8:0];
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   function automatic csp_entry_type rand_item();
      csp_entry_type t;
      t.op = OP_LOAD;
      t.entry_index = 8'($urandom);
      t.knot_x = $urandom;
      t.coef_a = $urandom;
      t.coef_b = $urandom;
      t.coef_c = $urandom;
      t.coef_d = $urandom;
      t.query_x = $urandom;
      return t;
   endfunction

   function automatic logic signed [31:0] rand_coef();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      if (r < 85) return $urandom;
      case ($urandom_range(0, 3))
         0: return 32'sh80000000;
         1: return 32'sh7FFFFFFF;
         2: return 32'sh0;
         default: return -32'sd1;
      endcase
   endfunction

   // rewrite entries 0..n-1 with sorted knots, wide or tightly spaced
   task automatic load_table(input int n, input bit descending);
      int ks[$];
      int base, span;
      csp_entry_type t;
      bit narrow;
      narrow = $urandom_range(0, 1);
      base = $urandom;
      span = $urandom_range(1 << 12, 1 << 24);
      ks.delete();
      for (int i = 0; i < n; i++)
         ks.push_back(narrow ? int'(sat_base(base, $urandom_range(0, span))) : int'($urandom));
      ks.sort();
      if (descending) ks.reverse();
      for (int i = 0; i < n; i++) begin
         t = rand_item();
         t.op = OP_LOAD;
         t.entry_index = 8'(i);
         t.knot_x = ks[i];
         t.coef_a = rand_coef();
         t.coef_b = rand_coef();
         t.coef_c = rand_coef();
         t.coef_d = rand_coef();
         send_item(t);
      end
   endtask

   function automatic logic signed [31:0] sat_base(input int base, input int off);
      return sb.sat32(longint'(base) + longint'(off));
   endfunction

   function automatic csp_entry_type query_at(input logic signed [31:0] qx, input bit deriv);
      csp_entry_type t;
      t = rand_item();
      t.op = deriv ? OP_DERIV : OP_VALUE;
      t.query_x = qx;
      return t;
   endfunction

   // random mix: mostly in-segment queries, some edges, noise, idle kinds and loads
   task automatic random_items(input int count);
      csp_entry_type t;
      int n, s, r;
      longint lo, hi, span;
      for (int k = 0; k < count; k++) begin
         n = sb.active_knots();
         r = $urandom_range(0, 99);
         s = $urandom_range(0, n - 2);
         lo = sb.knot[s];
         hi = sb.knot[s+1];
         if (r < 60) begin
            span = (hi > lo) ? hi - lo : lo - hi;
            if (span == 0) span = 1;
            lo = (hi > lo) ? lo : hi;
            t = query_at(32'(lo + longint'({$urandom, $urandom} % span)),
                         $urandom_range(0, 1));
         end else if (r < 72) begin
            t = query_at(sb.knot[$urandom_range(0, n - 1)], $urandom_range(0, 1));
         end else if (r < 80) begin
            t = query_at(sat_base(sb.knot[($urandom_range(0, 1)) ? 0 : n - 1],
                                  $urandom_range(0, 1) ? 1 : -1), $urandom_range(0, 1));
         end else if (r < 88) begin
            t = query_at($urandom, $urandom_range(0, 1));
         end else if (r < 94) begin
            t = rand_item();
            t.op = OP_NONE;
         end else begin
            t = rand_item();
            t.op = OP_LOAD;
         end
         send_item(t);
      end
   endtask

   initial begin : stimulus
      int settings[$];
      int n;
      csp_entry_type t;
      sb = new();
      cycles = 0;
      quiet = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_LOAD;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fill the whole table once so no query ever reads an unwritten entry
      csr_write(POINT_COUNT_RST);
      load_table(TABLE_DEPTH, 1'b0);
      drain();
      csr_write(TABLE_DEPTH);

      // directed: span edges, extremes, both query kinds, idle kind
      n = TABLE_DEPTH;
      send_item(query_at(sb.knot[0], 1'b0));
      send_item(query_at(sb.knot[0], 1'b1));
      send_item(query_at(sb.knot[n-1], 1'b0));
      send_item(query_at(sb.knot[n-1], 1'b1));
      send_item(query_at(sat_base(sb.knot[0], -1), 1'b0));
      send_item(query_at(sat_base(sb.knot[n-1], 1), 1'b1));
      send_item(query_at(32'sh80000000, 1'b0));
      send_item(query_at(32'sh7FFFFFFF, 1'b1));
      send_item(query_at(sb.knot[n/2] + 1, 1'b0));
      t = rand_item();
      t.op = OP_NONE;
      send_item(t);
      t = rand_item();
      t.op = OP_LOAD;
      t.entry_index = 8'(n - 1);
      t.knot_x = sb.knot[n-1];
      t.coef_a = 32'sh7FFFFFFF;
      t.coef_b = 32'sh80000000;
      t.coef_c = 32'sh7FFFFFFF;
      t.coef_d = 32'sh80000000;
      send_item(t);
      send_item(query_at(sb.knot[n-2] + 1, 1'b0));
      send_item(query_at(sb.knot[n-1], 1'b1));
      random_items(20);

      // register settings, clamped ones included; large ones keep the full table
      settings = '{511, 300, 2, 0, 1, 3, 5, 17, 64, 256};
      foreach (settings[i]) begin
         drain();
         quiet = (i % 4 == 3);
         csr_write(settings[i]);
         n = sb.active_knots();
         if (n <= 64) load_table(n, $urandom_range(0, 1));
         random_items(20);
      end

      drain();
      if (sb.mismatches == 0 && sb.result_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
